@@ rtl/core/oaht_pkg.sv @@
// ============================================================================
// oaht_pkg
// Shared widths, codes and controller/datapath interface types for the
// open-addressing hash table.
// ============================================================================
package oaht_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    // Fixed field widths.
    localparam int ACTION_W  = 2;
    localparam int KEY_ID_W  = 32;
    localparam int KEY_MAX_W = 64;
    localparam int HASH_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int LOAD_W    = 7;
    localparam int MARK_W    = 2;

    // Load limit after reset (three quarters of the default capacity).
    localparam logic [LOAD_W-1:0] LOAD_RESET = 7'd48;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_SET = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Slot marks.
    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture the input item
        logic clear;      // write one mark entry during the clearing pass
        logic home_ld;    // load the home slot and read it
        logic probe;      // evaluate the slot read in the previous cycle
        logic probe_adv;  // move on to the next slot
        logic commit;     // apply the update and load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is at its last entry
        logic home_done;  // home slot index is ready
        logic probe_end;  // current probe found the key, an empty slot or wrapped
        logic out_free;   // output register can take a new item
    } t_dp_sts;

endpackage

@@ rtl/core/oaht_home.sv @@
// ============================================================================
// oaht_home
// Reduces the key hash to a home slot index, hash modulo the capacity.
// A power-of-two capacity is a mask; otherwise a remainder unit takes four
// hash bits per cycle.
// ============================================================================
module oaht_home
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [HASH_W-1:0]            i_hash,
    output logic                         o_done,
    output logic [$clog2(CAPACITY)-1:0]  o_rem
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam bit POW2  = ((CAPACITY & (CAPACITY - 1)) == 0);

    if (POW2) begin : g_mask
        logic [IDX_W-1:0] r_rem;

        // The low hash bits are the slot index.
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= i_hash[IDX_W-1:0];
            end
        end

        assign o_done = 1'b1;
        assign o_rem  = r_rem;
    end else begin : g_div
        localparam int STEP  = 4;
        localparam int NSTEP = HASH_W / STEP;
        localparam int CNT_W = $clog2(NSTEP + 1);
        localparam int REM_W = IDX_W + 1;
        localparam logic [REM_W-1:0] CAP_R = REM_W'(CAPACITY);

        logic [HASH_W-1:0] r_hash;
        logic [REM_W-1:0]  r_rem;
        logic [REM_W-1:0]  n_rem;
        logic [CNT_W-1:0]  r_cnt;

        // Shift in four hash bits, most significant first, each followed
        // by one compare and subtract.
        always_comb begin
            n_rem = r_rem;
            for (int k = 0; k < STEP; k++) begin
                n_rem = {n_rem[REM_W-2:0], r_hash[HASH_W-1-k]};
                if (n_rem >= CAP_R) begin
                    n_rem = n_rem - CAP_R;
                end
            end
        end

        // Step counter.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt <= '0;
            end else if (i_start) begin
                r_cnt <= CNT_W'(NSTEP);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end

        // Remainder and remaining hash bits.
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_hash <= i_hash;
                r_rem  <= '0;
            end else if (r_cnt != '0) begin
                r_hash <= r_hash << STEP;
                r_rem  <= n_rem;
            end
        end

        assign o_done = (r_cnt == '0);
        assign o_rem  = r_rem[IDX_W-1:0];
    end

endmodule

@@ rtl/core/oaht_ctrl.sv @@
// ============================================================================
// oaht_ctrl
// Sequencer for the hash table: clearing pass after reset, then for each
// item home slot, linear probe and commit.
// ============================================================================
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HOME  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (i_sts.home_done) begin
                    o_cmd.home_ld = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.probe     = 1'b1;
                o_cmd.probe_adv = !i_sts.probe_end;
                if (i_sts.probe_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/oaht_datapath.sv @@
// ============================================================================
// oaht_datapath
// Slot memories, probe registers, load accounting, configuration register
// and output register of the hash table.
// ============================================================================
module oaht_datapath
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_we,
    input  logic [LOAD_W-1:0]   i_cfg_data,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [KEY_ID_W-1:0] i_key_id,
    input  logic [HASH_W-1:0]   i_key_hash,
    input  logic [VALUE_W-1:0]  i_value_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_value_out
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int UC_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((UC_W > LOAD_W) ? UC_W : LOAD_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Slot memories.
    logic [KEY_BITS-1:0] key_mem  [CAPACITY];
    logic [VALUE_W-1:0]  val_mem  [CAPACITY];
    logic [MARK_W-1:0]   mark_mem [CAPACITY];

    // Captured item.
    logic [ACTION_W-1:0] r_action;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_W-1:0]  r_value;
    logic [KEY_MAX_W-1:0] key_ext;

    // Probe state.
    logic [IDX_W-1:0]    home;
    logic                home_done;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    idx_nxt;
    logic [IDX_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] r_key_q;
    logic [VALUE_W-1:0]  r_val_q;
    logic [MARK_W-1:0]   r_mark_q;
    logic                hit_c;
    logic                empty_c;
    logic                r_hit;
    logic                r_empty;
    logic                r_tomb_vld;
    logic [IDX_W-1:0]    r_tomb_idx;

    // Bookkeeping.
    logic [IDX_W-1:0]    r_clr_idx;
    logic [UC_W-1:0]     r_used;
    logic [LOAD_W-1:0]   r_max_load;
    logic                room;

    // Commit decision.
    logic [STATUS_W-1:0] n_status;
    logic [VALUE_W-1:0]  n_value_out;
    logic [IDX_W-1:0]    wr_idx;
    logic                key_we_c;
    logic                val_we_c;
    logic                mark_we_c;
    logic [MARK_W-1:0]   mark_wdata_c;
    logic                used_inc_c;

    // Memory write ports.
    logic                mark_we;
    logic [IDX_W-1:0]    mark_waddr;
    logic [MARK_W-1:0]   mark_wdata;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_value;
    logic                out_free;

    // Home slot reduction.
    oaht_home #(
        .CAPACITY (CAPACITY)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept),
        .i_hash  (i_key_hash),
        .o_done  (home_done),
        .o_rem   (home)
    );

    // Only the low KEY_BITS bits of the key identity take part.
    assign key_ext = {{(KEY_MAX_W - KEY_ID_W){1'b0}}, i_key_id};

    // Capture the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_key    <= key_ext[KEY_BITS-1:0];
            r_value  <= i_value_in;
        end
    end

    // Slot evaluation for the entry read in the previous cycle.
    assign idx_nxt = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign hit_c   = (r_mark_q == MARK_LIVE) && (r_key_q == r_key);
    assign empty_c = (r_mark_q == MARK_EMPTY);

    // Read address: home slot, next slot, or hold the current one.
    always_comb begin
        if (i_cmd.home_ld) begin
            rd_addr = home;
        end else if (i_cmd.probe_adv) begin
            rd_addr = idx_nxt;
        end else begin
            rd_addr = r_idx;
        end
    end

    // Probe index, count and outcome flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.home_ld) begin
            r_idx <= home;
            r_cnt <= '0;
        end else if (i_cmd.probe_adv) begin
            r_idx <= idx_nxt;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.probe) begin
            r_hit   <= hit_c;
            r_empty <= empty_c;
        end
    end

    // First tombstone passed on the way.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tomb_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_tomb_vld <= 1'b0;
        end else if (i_cmd.probe && (r_mark_q == MARK_TOMB) && !r_tomb_vld) begin
            r_tomb_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe && (r_mark_q == MARK_TOMB) && !r_tomb_vld) begin
            r_tomb_idx <= r_idx;
        end
    end

    // Insert into an empty slot only while the load limit allows.
    assign room = (CMP_W'(r_used) + CMP_W'(1)) <= CMP_W'(r_max_load);

    // Outcome of the request and the writes it needs.
    always_comb begin
        n_status     = ST_NOT_FOUND;
        n_value_out  = '0;
        wr_idx       = r_idx;
        key_we_c     = 1'b0;
        val_we_c     = 1'b0;
        mark_we_c    = 1'b0;
        mark_wdata_c = MARK_LIVE;
        used_inc_c   = 1'b0;
        case (r_action)
            ACT_SET: begin
                if (r_hit) begin
                    val_we_c = 1'b1;
                    n_status = ST_UPDATED;
                end else if (r_tomb_vld) begin
                    wr_idx    = r_tomb_idx;
                    key_we_c  = 1'b1;
                    val_we_c  = 1'b1;
                    mark_we_c = 1'b1;
                    n_status  = ST_NEW;
                end else if (r_empty && room) begin
                    key_we_c   = 1'b1;
                    val_we_c   = 1'b1;
                    mark_we_c  = 1'b1;
                    used_inc_c = 1'b1;
                    n_status   = ST_NEW;
                end else begin
                    n_status = ST_FULL;
                end
            end
            ACT_GET: begin
                if (r_hit) begin
                    n_status    = ST_FOUND;
                    n_value_out = r_val_q;
                end
            end
            ACT_DEL: begin
                if (r_hit) begin
                    mark_we_c    = 1'b1;
                    mark_wdata_c = MARK_TOMB;
                    n_status     = ST_DELETED;
                end
            end
            default: begin
            end
        endcase
    end

    // Key and value memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && key_we_c) begin
            key_mem[wr_idx] <= r_key;
        end
        r_key_q <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && val_we_c) begin
            val_mem[wr_idx] <= r_value;
        end
        r_val_q <= val_mem[rd_addr];
    end

    // Mark memory, shared by the clearing pass and commits.
    assign mark_we    = i_cmd.clear || (i_cmd.commit && mark_we_c);
    assign mark_waddr = i_cmd.clear ? r_clr_idx : wr_idx;
    assign mark_wdata = i_cmd.clear ? MARK_EMPTY : mark_wdata_c;

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        r_mark_q <= mark_mem[rd_addr];
    end

    // Clearing pass counter, used count and load limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_used     <= '0;
            r_max_load <= LOAD_RESET;
        end else begin
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.commit && used_inc_c) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cfg_we) begin
                r_max_load <= i_cfg_data;
            end
        end
    end

    // Output register: a finished item waits here while the next one runs.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_value  <= n_value_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_out = r_out_value;

    // Status to the controller.
    assign o_sts.clr_last  = (r_clr_idx == LAST_IDX);
    assign o_sts.home_done = home_done;
    assign o_sts.probe_end = hit_c || empty_c || (r_cnt == LAST_IDX);
    assign o_sts.out_free  = out_free;

    // A commit never overwrites a result that has not been taken.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("Commit while the output register is occupied.");

    // Every commit presents an item in the next cycle.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("Committed item did not reach the output register.");

    // Live plus tombstone slots never exceed the table.
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UC_W'(CAPACITY))
        else $error("Used count exceeds the capacity.");

    // Deletes leave tombstones, so the used count never drops.
    a_used_mono: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_used >= $past(r_used)))
        else $error("Used count decreased.");

endmodule

@@ rtl/core/open_address_hash_table.sv @@
// ============================================================================
// open_address_hash_table
// An accepted item passes through the home slot reduction, a linear probe of 1
// to CAPACITY slots and the commit into the output register; a capacity that is
// not a power of two uses the remainder unit. A new item is taken only after the
// previous one has committed; the probe reads one slot per cycle over the slot
// memories' single read port. Reset starts a clearing pass of the slot marks with s_axis_tready low.
// ============================================================================
module open_address_hash_table
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Configuration: load limit.
    input  logic                                       i_cfg_we,
    input  logic [LOAD_W-1:0]                          i_cfg_data,
    // Request stream.
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [31:0] key_id, [63:32] key_hash, [127:64] value_in
    input  logic [KEY_ID_W+HASH_W+VALUE_W-1:0]         s_axis_tdata,
    // [1:0] action
    input  logic [ACTION_W-1:0]                        s_axis_tuser,
    // Result stream.
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // [63:0] value_out
    output logic [VALUE_W-1:0]                         m_axis_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]                        m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    oaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table storage and result path.
    oaht_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_axis_tuser),
        .i_key_id    (s_axis_tdata[KEY_ID_W-1:0]),
        .i_key_hash  (s_axis_tdata[KEY_ID_W+HASH_W-1:KEY_ID_W]),
        .i_value_in  (s_axis_tdata[KEY_ID_W+HASH_W+VALUE_W-1:KEY_ID_W+HASH_W]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_value_out (m_axis_tdata)
    );

endmodule
